// ----- design/swpcc_pkg.sv -----
// swpcc_pkg: shared widths, crc constants, frame position codes and the crc fold
// function for the sensor word pair crc checker
// no dependencies
package swpcc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 16;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;

  typedef enum logic [2:0] {
    POS_T_HI,
    POS_T_LO,
    POS_T_CRC,
    POS_H_HI,
    POS_H_LO,
    POS_H_CRC
  } pos_t;

  // msb-first crc-8 over one byte
  function automatic logic [BYTE_W-1:0] crc_fold(input logic [BYTE_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    v = acc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if ((v & CRC_TOP) != '0) begin
        v = (v << 1) ^ CRC_POLY;
      end else begin
        v = v << 1;
      end
    end
    return v;
  endfunction

endpackage

// ----- design/swpcc_if.sv -----
// swpcc_in_if and swpcc_out_if: valid/ready channels for received bytes and
// for checked word pairs
// depends on swpcc_pkg
interface swpcc_in_if (
  input logic clk
);
  logic                           valid;
  logic                           ready;
  logic [swpcc_pkg::BYTE_W-1:0]   data_byte;
  logic                           frame_start;

  modport source (input clk, output valid, output data_byte, output frame_start, input ready);
  modport sink   (input clk, input valid, input data_byte, input frame_start, output ready);
endinterface

interface swpcc_out_if (
  input logic clk
);
  logic                           valid;
  logic                           ready;
  logic [swpcc_pkg::WORD_W-1:0]   temperature_raw;
  logic [swpcc_pkg::WORD_W-1:0]   humidity_raw;
  logic                           temperature_ok;
  logic                           humidity_ok;

  modport source (input clk, output valid, output temperature_raw, output humidity_raw,
                  output temperature_ok, output humidity_ok, input ready);
  modport sink   (input clk, input valid, input temperature_raw, input humidity_raw,
                  input temperature_ok, input humidity_ok, output ready);
endinterface

// ----- design/sensor_word_pair_crc_checker_unit.sv -----
// sensor_word_pair_crc_checker_unit: top level, collects six response bytes and
// checks the temperature and humidity words with crc-8
// depends on swpcc_pkg and the channel interfaces in swpcc_if.sv
//
// usage
//   in_chan carries one response byte per item with a frame_start flag; byte order
//   is temperature high, low, crc, humidity high, low, crc. frame_start restarts
//   the frame at the first byte; after the sixth byte the next byte starts a new
//   frame by itself.
//   out_chan carries one item per complete frame: both raw words (zero if their
//   crc failed) and a pass flag for each.
//   throughput: one byte per cycle while no result waits on a stalled out_chan,
//   set by the single byte-wide crc fold between the input register and the state
//   and result registers. pipeline: a byte is held in the input register, then
//   folded into the frame state, and the sixth byte writes the result register.
//   when the receiver stalls, the result holds in the output register and the
//   input register still takes one more byte; in_chan.ready drops only when
//   that byte cannot be folded because a result is still waiting.
//   reset: rst_n (synchronous, active low) empties both registers, sets the frame
//   position to the first byte and the running crc to 0xff.
module sensor_word_pair_crc_checker_unit (
  input  logic               clk,
  input  logic               rst_n,
  swpcc_in_if.sink           in_chan,
  swpcc_out_if.source        out_chan
);

  logic                           in_v_r;
  logic [swpcc_pkg::BYTE_W-1:0]   byte_r;
  logic                           start_r;

  swpcc_pkg::pos_t                pos_r, pos_nxt, pos_eff;
  logic [swpcc_pkg::BYTE_W-1:0]   crc_r, crc_nxt, crc_base, crc_folded;
  logic [swpcc_pkg::WORD_W-1:0]   temp_word_r, temp_word_nxt;
  logic [swpcc_pkg::WORD_W-1:0]   hum_word_r, hum_word_nxt;
  logic                           temp_pass_r, temp_pass_nxt;
  logic                           hum_pass;
  logic                           res_go;

  logic                           out_v_r;
  logic [swpcc_pkg::WORD_W-1:0]   temp_raw_r, hum_raw_r;
  logic                           temp_ok_r, hum_ok_r;

  logic                           proc_go;

  assign proc_go       = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || proc_go;

  always_comb begin
    pos_eff       = start_r ? swpcc_pkg::POS_T_HI : pos_r;
    crc_base      = start_r ? swpcc_pkg::CRC_INIT : crc_r;
    crc_folded    = swpcc_pkg::crc_fold(crc_base, byte_r);
    hum_pass      = (crc_base == byte_r);
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    hum_word_nxt  = hum_word_r;
    temp_pass_nxt = temp_pass_r;
    res_go        = 1'b0;
    case (pos_eff)
      swpcc_pkg::POS_T_HI: begin
        crc_nxt       = crc_folded;
        temp_word_nxt = {byte_r, temp_word_r[swpcc_pkg::BYTE_W-1:0]};
        pos_nxt       = swpcc_pkg::POS_T_LO;
      end
      swpcc_pkg::POS_T_LO: begin
        crc_nxt       = crc_folded;
        temp_word_nxt = {temp_word_r[swpcc_pkg::WORD_W-1:swpcc_pkg::BYTE_W], byte_r};
        pos_nxt       = swpcc_pkg::POS_T_CRC;
      end
      swpcc_pkg::POS_T_CRC: begin
        temp_pass_nxt = (crc_base == byte_r);
        crc_nxt       = swpcc_pkg::CRC_INIT;
        pos_nxt       = swpcc_pkg::POS_H_HI;
      end
      swpcc_pkg::POS_H_HI: begin
        crc_nxt      = crc_folded;
        hum_word_nxt = {byte_r, hum_word_r[swpcc_pkg::BYTE_W-1:0]};
        pos_nxt      = swpcc_pkg::POS_H_LO;
      end
      swpcc_pkg::POS_H_LO: begin
        crc_nxt      = crc_folded;
        hum_word_nxt = {hum_word_r[swpcc_pkg::WORD_W-1:swpcc_pkg::BYTE_W], byte_r};
        pos_nxt      = swpcc_pkg::POS_H_CRC;
      end
      swpcc_pkg::POS_H_CRC: begin
        crc_nxt = swpcc_pkg::CRC_INIT;
        pos_nxt = swpcc_pkg::POS_T_HI;
        res_go  = 1'b1;
      end
      default: begin
        crc_nxt = swpcc_pkg::CRC_INIT;
        pos_nxt = swpcc_pkg::POS_T_HI;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      byte_r  <= in_chan.data_byte;
      start_r <= in_chan.frame_start;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= swpcc_pkg::POS_T_HI;
      crc_r       <= swpcc_pkg::CRC_INIT;
      temp_word_r <= '0;
      hum_word_r  <= '0;
      temp_pass_r <= 1'b0;
    end else if (proc_go) begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      temp_word_r <= temp_word_nxt;
      hum_word_r  <= hum_word_nxt;
      temp_pass_r <= temp_pass_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc_go && res_go) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res_go) begin
      temp_raw_r <= temp_pass_r ? temp_word_r : '0;
      hum_raw_r  <= hum_pass ? hum_word_nxt : '0;
      temp_ok_r  <= temp_pass_r;
      hum_ok_r   <= hum_pass;
    end
  end

  assign out_chan.valid           = out_v_r;
  assign out_chan.temperature_raw = temp_raw_r;
  assign out_chan.humidity_raw    = hum_raw_r;
  assign out_chan.temperature_ok  = temp_ok_r;
  assign out_chan.humidity_ok     = hum_ok_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == swpcc_pkg::POS_T_HI || pos_r == swpcc_pkg::POS_T_LO ||
    pos_r == swpcc_pkg::POS_T_CRC || pos_r == swpcc_pkg::POS_H_HI ||
    pos_r == swpcc_pkg::POS_H_LO || pos_r == swpcc_pkg::POS_H_CRC)
    else $error("frame position out of range");

  a_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !temp_ok_r |-> temp_raw_r == '0)
    else $error("failed temperature word not zeroed");

  a_hum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !hum_ok_r |-> hum_raw_r == '0)
    else $error("failed humidity word not zeroed");

  a_last_byte_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go && pos_eff == swpcc_pkg::POS_H_CRC |=> out_v_r && pos_r == swpcc_pkg::POS_T_HI)
    else $error("sixth byte did not produce a result");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !proc_go |=> in_v_r && $stable(byte_r) && $stable(start_r))
    else $error("held byte lost while stalled");

endmodule
